// ===== hdl/arg_pkg.sv =====
// Shared types, constants and helpers for the acceleration ramp generator.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none

package arg_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned EL_W       = 16;
  localparam int unsigned PROG_W     = 17;
  localparam int unsigned DIV_STEPS  = 17;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 56;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [PROG_W-1:0] PROG_ONE = 17'd65536;
  localparam logic [PROG_W-1:0] PROG_MAX = 17'd131071;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_TARGET = 2'd1,
    REG_VELO   = 2'd2,
    REG_ACCEL  = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_VEL,
    S_MULX,
    S_POS,
    S_PREP,
    S_DIV,
    S_FIN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic start;
    logic stop;
    logic mul_accel;
    logic mul_vel;
    logic upd_vel;
    logic upd_pos;
    logic div_init;
    logic div_step;
    logic prog_write;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic running;
    logic out_busy;
  } dp_status_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
    logic [DATA_W-1:0] r;
    if (!v[DATA_W+1] && (v[DATA_W] || v[DATA_W-1])) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v[DATA_W+1] && !(v[DATA_W] && v[DATA_W-1])) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/arg_ctrl.sv =====
// Sequencing controller for the acceleration ramp generator.
// Depends on arg_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module arg_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic [1:0]             in_cmd_i,
  output logic                        in_ready_o,
  input  wire arg_pkg::dp_status_t    status_i,
  output arg_pkg::ctrl_cmd_t          cmd_o
);

  arg_pkg::state_e            state_q, state_d;
  logic [arg_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arg_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      arg_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = arg_pkg::S_OUT;
          case (arg_pkg::cmd_e'(in_cmd_i))
            arg_pkg::CMD_START: cmd_o.start = 1'b1;
            arg_pkg::CMD_STOP:  cmd_o.stop = 1'b1;
            arg_pkg::CMD_TICK: begin
              if (status_i.running) begin
                state_d = arg_pkg::S_ACC;
              end
            end
            default: ;
          endcase
        end
      end
      arg_pkg::S_ACC: begin
        cmd_o.mul_accel = 1'b1;
        state_d = arg_pkg::S_VEL;
      end
      arg_pkg::S_VEL: begin
        cmd_o.upd_vel = 1'b1;
        state_d = arg_pkg::S_MULX;
      end
      arg_pkg::S_MULX: begin
        cmd_o.mul_vel = 1'b1;
        state_d = arg_pkg::S_POS;
      end
      arg_pkg::S_POS: begin
        cmd_o.upd_pos = 1'b1;
        state_d = arg_pkg::S_PREP;
      end
      arg_pkg::S_PREP: begin
        cmd_o.div_init = 1'b1;
        cnt_d = '0;
        state_d = arg_pkg::S_DIV;
      end
      arg_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == arg_pkg::CNT_W'(arg_pkg::DIV_STEPS - 1)) begin
          state_d = arg_pkg::S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      arg_pkg::S_FIN: begin
        cmd_o.prog_write = 1'b1;
        state_d = arg_pkg::S_OUT;
      end
      arg_pkg::S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = arg_pkg::S_IDLE;
        end
      end
      default: state_d = arg_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/arg_datapath.sv =====
// Datapath of the acceleration ramp generator: configuration, ramp state,
// shared multiplier, restoring divider for progress and output register. Uses arg_pkg.
`default_nettype none

module arg_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [arg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [arg_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  wire logic [arg_pkg::EL_W-1:0]          in_elapsed_i,
  input  wire arg_pkg::ctrl_cmd_t                cmd_i,
  output arg_pkg::dp_status_t                    status_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [arg_pkg::M_TDATA_W-1:0]          out_data_o
);

  localparam int unsigned DW   = arg_pkg::DATA_W;
  localparam int unsigned PW   = DW + arg_pkg::EL_W + 1;
  localparam int unsigned PADW = arg_pkg::M_TDATA_W - arg_pkg::PROG_W - DW - 1;

  logic signed [DW-1:0]           cfg_start_q, cfg_target_q, cfg_velo_q, cfg_accel_q;
  logic signed [DW-1:0]           lat_start_q, lat_target_q, lat_accel_q;
  logic signed [DW-1:0]           value_q, vel_q;
  logic                           running_q;
  logic [arg_pkg::PROG_W-1:0]     prog_q;
  logic [arg_pkg::EL_W-1:0]       el_q;
  logic signed [PW-1:0]           prod_q;
  logic [DW+1:0]                  rem_q;
  logic [DW:0]                    den_q;
  logic [arg_pkg::PROG_W-1:0]     quo_q;
  logic                           den_zero_q, over_q;
  logic                           out_valid_q;
  logic [arg_pkg::M_TDATA_W-1:0]  out_data_q;

  logic signed [DW-1:0]           mul_a;
  logic signed [PW-1:0]           prod_d;
  logic signed [DW:0]             step_w;
  logic signed [DW+1:0]           vel_sum, pos_sum;
  logic signed [DW-1:0]           vel_sat, pos_sat;
  logic                           up, reached;
  logic signed [DW:0]             den_diff, num_diff;
  logic [DW:0]                    den_abs, num_abs;
  logic                           div_ge;
  logic [DW+1:0]                  div_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q  <= '0;
      cfg_target_q <= '0;
      cfg_velo_q   <= '0;
      cfg_accel_q  <= '0;
    end else if (cfg_we_i) begin
      case (arg_pkg::reg_idx_e'(cfg_idx_i))
        arg_pkg::REG_START:  cfg_start_q  <= cfg_wdata_i;
        arg_pkg::REG_TARGET: cfg_target_q <= cfg_wdata_i;
        arg_pkg::REG_VELO:   cfg_velo_q   <= cfg_wdata_i;
        arg_pkg::REG_ACCEL:  cfg_accel_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign mul_a   = cmd_i.mul_vel ? vel_q : lat_accel_q;
  assign prod_d  = PW'(mul_a) * PW'($signed({1'b0, el_q}));
  assign step_w  = $signed(prod_q[PW-1:arg_pkg::EL_W]);

  assign vel_sum = (DW+2)'(vel_q) + (DW+2)'(step_w);
  assign vel_sat = $signed(arg_pkg::sat32(vel_sum));

  assign up      = (lat_target_q >= lat_start_q);
  assign pos_sum = up ? ((DW+2)'(value_q) + (DW+2)'(step_w))
                      : ((DW+2)'(value_q) - (DW+2)'(step_w));
  assign pos_sat = $signed(arg_pkg::sat32(pos_sum));
  assign reached = up ? (pos_sat >= lat_target_q) : (pos_sat <= lat_target_q);

  assign den_diff = (DW+1)'(lat_start_q) - (DW+1)'(lat_target_q);
  assign num_diff = (DW+1)'(lat_start_q) - (DW+1)'(value_q);
  assign den_abs  = den_diff[DW] ? (DW+1)'(-den_diff) : den_diff;
  assign num_abs  = num_diff[DW] ? (DW+1)'(-num_diff) : num_diff;

  assign div_ge  = (rem_q >= {1'b0, den_q});
  assign div_rem = div_ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q      <= '0;
      vel_q        <= '0;
      running_q    <= 1'b0;
      prog_q       <= '0;
      lat_start_q  <= '0;
      lat_target_q <= '0;
      lat_accel_q  <= '0;
    end else begin
      if (cmd_i.start) begin
        lat_start_q  <= cfg_start_q;
        lat_target_q <= cfg_target_q;
        lat_accel_q  <= cfg_accel_q;
        value_q      <= cfg_start_q;
        vel_q        <= cfg_velo_q;
        running_q    <= 1'b1;
      end
      if (cmd_i.stop) begin
        running_q <= 1'b0;
      end
      if (cmd_i.upd_vel) begin
        vel_q <= vel_sat;
      end
      if (cmd_i.upd_pos) begin
        if (reached) begin
          value_q   <= lat_target_q;
          running_q <= 1'b0;
        end else begin
          value_q <= pos_sat;
        end
      end
      if (cmd_i.prog_write) begin
        if (den_zero_q) begin
          prog_q <= arg_pkg::PROG_ONE;
        end else if (over_q) begin
          prog_q <= arg_pkg::PROG_MAX;
        end else begin
          prog_q <= quo_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      el_q <= in_elapsed_i;
    end
    if (cmd_i.mul_accel || cmd_i.mul_vel) begin
      prod_q <= prod_d;
    end
    if (cmd_i.div_init) begin
      rem_q      <= {1'b0, num_abs};
      den_q      <= den_abs;
      quo_q      <= '0;
      den_zero_q <= (den_abs == '0);
      over_q     <= ({1'b0, num_abs} >= {den_abs, 1'b0});
    end else if (cmd_i.div_step) begin
      rem_q <= {div_rem[DW:0], 1'b0};
      quo_q <= {quo_q[arg_pkg::PROG_W-2:0], div_ge};
    end
    if (cmd_i.out_load) begin
      out_data_q <= {{PADW{1'b0}}, prog_q, value_q, running_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.running  = running_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/accel_ramp_generator.sv =====
// Top level of the constant-acceleration ramp generator in Q16.16.
// Instantiates arg_ctrl and arg_datapath; uses arg_pkg.
//
// Usage: write start, target, initial velocity and acceleration through
// the configuration port (index 0 to 3), then send a start command on the
// input stream. Each input transaction carries the command in tuser and
// the elapsed time of a tick in tdata. Every input transaction yields one
// output transaction with the active flag, the current value and progress.
// A tick on an active ramp loads the output register after acceptance, once
// it has made two passes through the shared 32x17 multiplier with a velocity
// update between them, one position update, and 17 steps of the restoring
// progress divider. Start, stop and ticks on an idle ramp load it without
// using the multiplier or divider. One item is processed at a time, so
// the input is held off until its result is in the output register.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, a finished item holds in the controller until the
// output register frees. Reset clears the configuration and the ramp state.
`default_nettype none

module accel_ramp_generator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [arg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [arg_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // elapsed[15:0]
  input  wire logic [arg_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // command[1:0]
  input  wire logic [arg_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // active[0], current_value[32:1], progress[49:33], zero[55:50]
  output logic [arg_pkg::M_TDATA_W-1:0]          m_axis_tdata
);

  arg_pkg::ctrl_cmd_t  ctrl_cmd;
  arg_pkg::dp_status_t dp_status;

  arg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  arg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_elapsed_i (s_axis_tdata),
    .cmd_i        (ctrl_cmd),
    .status_o     (dp_status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/arg_checker.sv =====
// Port-level checks for the acceleration ramp generator, bound to the top.
// Depends on arg_pkg and accel_ramp_generator.
`default_nettype none

module arg_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [arg_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [arg_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  // Only one transaction is in flight, so ready drops after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  // Ready returns only once the result has been placed on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid)
    else $error("input ready returned without a pending result");

  // A stop command always reports an inactive ramp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == arg_pkg::CMD_STOP)
      |=> s_axis_tready[->1] ##0 (m_axis_tvalid && !m_axis_tdata[0]))
    else $error("stop command did not report an inactive ramp");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output changed");

endmodule

bind accel_ramp_generator arg_checker u_arg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
